>>> hdl/deps_pkg.sv
// Package for the deadline event pool scheduler: constants, result kinds, controller states.
package deps_pkg;

	localparam int unsigned POOL_SIZE_DEF = 16;

	localparam int unsigned TAG_W    = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DELAY_W  = 20;
	localparam int unsigned SLEEP_W  = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned ENTRY_W  = TAG_W + TIME_W;

	localparam logic [SLEEP_W-1:0] TURNAROUND_RST = 16'd100;

	localparam logic REG_TURNAROUND = 1'b0;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_PROCESS = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ENQ_ANSWER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLEEP      = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SCAN,
		ST_WALK,
		ST_REPORT
	} ctl_state_t;

endpackage

>>> hdl/deadline_event_pool_scheduler.sv
// Deadline event pool scheduler: timed event pool kept as a linked list in slot memories.
// Enqueue: result registered in ST_ENQ; cmd_stall holds off the next command until then.
// Process with N pending: a scan of up to N entries (stops at the first event not due),
// then a walk of all N entries through the link memory read port, one entry per cycle
// while the result side takes fired events; then the sleep report.
// Reset clears control state; all slots start free, memories need no clearing.
module deadline_event_pool_scheduler #(
	parameter int unsigned POOL_SIZE = deps_pkg::POOL_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic                           command,
	input  logic [deps_pkg::TIME_W-1:0]    now_time,
	input  logic [deps_pkg::TAG_W-1:0]     event_tag,
	input  logic [deps_pkg::DELAY_W-1:0]   delay_time,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [deps_pkg::KIND_W-1:0]    kind,
	output logic [deps_pkg::TAG_W-1:0]     fired_tag,
	output logic                           accepted,
	output logic [deps_pkg::SLEEP_W-1:0]   sleep_time,
	output logic                           any_pending,
	output logic                           last
);

	import deps_pkg::*;

	localparam int unsigned IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int unsigned CW = $clog2(POOL_SIZE + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(POOL_SIZE);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);
	localparam logic [IW-1:0] IDX_LAST = IW'(POOL_SIZE - 1);

	ctl_state_t st_q, st_d;

	logic [SLEEP_W-1:0] turnaround_q;
	logic [IW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      fresh_q;
	logic [IW-1:0]      fwr_q, frd_q;
	logic [CW-1:0]      rem_q;
	logic [IW-1:0]      cur_q;
	logic [CW-1:0]      nkeep_q;
	logic [IW-1:0]      nhead_q, lastk_q;
	logic               fired_q, anyp_q, full_q;
	logic [SLEEP_W-1:0] sleep_q;
	logic [TIME_W-1:0]  now_q;
	logic [TAG_W-1:0]   tag_q;
	logic [DELAY_W-1:0] delay_q;

	logic               res_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TAG_W-1:0]   fired_tag_q;
	logic               accepted_q;
	logic [SLEEP_W-1:0] sleep_time_q;
	logic               any_pending_q;
	logic               last_q;

	logic               ent_we;
	logic [IW-1:0]      ent_waddr;
	logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
	logic               lnk_we;
	logic [IW-1:0]      lnk_waddr, lnk_wdata, lnk_rdata;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               fre_we, fre_re;
	logic [IW-1:0]      fre_rdata;

	logic               take, ofree, cfg_wr;
	logic [TIME_W-1:0]  diff;
	logic               due, last_entry, walk_step;
	logic               use_fresh;
	logic [IW-1:0]      new_slot;
	logic [TIME_W-1:0]  expiry;
	logic               enq_do, fire_do, report_do, keep_do;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_TURNAROUND) ? {16'b0, turnaround_q} : 32'b0;

	assign cmd_stall = (st_q != ST_IDLE);
	assign take      = cmd_valid && !cmd_stall;
	assign ofree     = !res_valid_q || !res_stall;

	assign diff       = ent_rdata[TIME_W-1:0] - now_q;
	assign due        = (diff == '0) || diff[TIME_W-1];
	assign last_entry = (rem_q == CNT_ONE);
	assign walk_step  = !due || ofree;

	assign use_fresh = (fresh_q != CNT_FULL);
	assign new_slot  = use_fresh ? fresh_q[IW-1:0] : fre_rdata;
	assign expiry    = now_q + {{(TIME_W - DELAY_W){1'b0}}, delay_q};

	assign enq_do    = (st_q == ST_ENQ) && ofree;
	assign fire_do   = (st_q == ST_WALK) && due && ofree;
	assign keep_do   = (st_q == ST_WALK) && !due;
	assign report_do = (st_q == ST_REPORT) && ofree;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (take) begin
					if (command == CMD_ENQUEUE) begin
						st_d = ST_ENQ;
					end else if (count_q == '0) begin
						st_d = ST_REPORT;
					end else begin
						st_d = ST_SCAN;
					end
				end
			end
			ST_ENQ: begin
				if (ofree) begin
					st_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!due || last_entry) begin
					st_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_step && last_entry) begin
					st_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (ofree) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = lnk_rdata;
		fre_re    = 1'b0;
		ent_we    = 1'b0;
		ent_waddr = new_slot;
		ent_wdata = {tag_q, expiry};
		lnk_we    = 1'b0;
		lnk_waddr = tail_q;
		lnk_wdata = new_slot;
		fre_we    = fire_do;
		unique case (st_q)
			ST_IDLE: begin
				rd_en   = take && (command == CMD_PROCESS);
				rd_addr = head_q;
				fre_re  = take && (command == CMD_ENQUEUE);
			end
			ST_ENQ: begin
				ent_we = enq_do && !full_q;
				lnk_we = enq_do && !full_q && (count_q != '0);
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (!due || last_entry) begin
					rd_addr = head_q;
				end
			end
			ST_WALK: begin
				rd_en     = walk_step;
				lnk_we    = keep_do && (nkeep_q != '0);
				lnk_waddr = lastk_q;
				lnk_wdata = cur_q;
			end
			ST_REPORT: begin
			end
			default: begin
			end
		endcase
	end

	deps_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_SIZE)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ent_rdata)
	);

	deps_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (lnk_rdata)
	);

	deps_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_free_ram (
		.clk   (clk),
		.we    (fre_we),
		.waddr (fwr_q),
		.wdata (cur_q),
		.re    (fre_re),
		.raddr (frd_q),
		.rdata (fre_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			turnaround_q <= TURNAROUND_RST;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			fresh_q      <= '0;
			fwr_q        <= '0;
			frd_q        <= '0;
			rem_q        <= '0;
			nkeep_q      <= '0;
			fired_q      <= 1'b0;
			anyp_q       <= 1'b0;
			full_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wr && (paddr[2] == REG_TURNAROUND)) begin
				turnaround_q <= pwdata[SLEEP_W-1:0];
			end
			if (take) begin
				full_q  <= (count_q == CNT_FULL);
				rem_q   <= count_q;
				nkeep_q <= '0;
				fired_q <= 1'b0;
				anyp_q  <= 1'b0;
			end
			if (enq_do && !full_q) begin
				if (count_q == '0) begin
					head_q <= new_slot;
				end
				tail_q  <= new_slot;
				count_q <= count_q + CNT_ONE;
				if (use_fresh) begin
					fresh_q <= fresh_q + CNT_ONE;
				end else begin
					frd_q <= (frd_q == IDX_LAST) ? '0 : frd_q + IW'(1);
				end
			end
			if (st_q == ST_SCAN) begin
				if (!due) begin
					anyp_q <= 1'b1;
				end
				if (!due || last_entry) begin
					rem_q <= count_q;
				end else begin
					rem_q <= rem_q - CNT_ONE;
				end
			end
			if ((st_q == ST_WALK) && walk_step) begin
				rem_q <= rem_q - CNT_ONE;
			end
			if (fire_do) begin
				fired_q <= 1'b1;
				fwr_q   <= (fwr_q == IDX_LAST) ? '0 : fwr_q + IW'(1);
			end
			if (keep_do) begin
				nkeep_q <= nkeep_q + CNT_ONE;
			end
			if (report_do) begin
				count_q <= nkeep_q;
				head_q  <= (nkeep_q != '0) ? nhead_q : '0;
				tail_q  <= (nkeep_q != '0) ? lastk_q : '0;
			end
			if (enq_do || fire_do || report_do) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_q   <= now_time;
			tag_q   <= event_tag;
			delay_q <= delay_time;
			sleep_q <= turnaround_q;
		end
		if (rd_en) begin
			cur_q <= rd_addr;
		end
		if (keep_do) begin
			if (nkeep_q == '0) begin
				nhead_q <= cur_q;
			end
			lastk_q <= cur_q;
			if (diff < {{(TIME_W - SLEEP_W){1'b0}}, sleep_q}) begin
				sleep_q <= diff[SLEEP_W-1:0];
			end
		end
		if (enq_do) begin
			kind_q        <= KIND_ENQ_ANSWER;
			fired_tag_q   <= '0;
			accepted_q    <= !full_q;
			sleep_time_q  <= '0;
			any_pending_q <= !full_q || (count_q != '0);
			last_q        <= 1'b1;
		end else if (fire_do) begin
			kind_q        <= KIND_FIRED;
			fired_tag_q   <= ent_rdata[ENTRY_W-1:TIME_W];
			accepted_q    <= 1'b0;
			sleep_time_q  <= '0;
			any_pending_q <= anyp_q;
			last_q        <= 1'b0;
		end else if (report_do) begin
			kind_q        <= KIND_SLEEP;
			fired_tag_q   <= '0;
			accepted_q    <= 1'b0;
			sleep_time_q  <= fired_q ? '0 : sleep_q;
			any_pending_q <= (nkeep_q != '0);
			last_q        <= 1'b1;
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign fired_tag   = fired_tag_q;
	assign accepted    = accepted_q;
	assign sleep_time  = sleep_time_q;
	assign any_pending = any_pending_q;
	assign last        = last_q;

endmodule

>>> hdl/deps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module deps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
